// ===== rtl/ffsa_pkg.sv =====
// Shared constants and types for the first-fit space allocator.
`default_nettype none
package ffsa_pkg;
    localparam int MAX_SEG = 64;
    localparam int ID_BITS = 16;
    localparam int LEN_W   = 31;
    localparam int IDX_W   = $clog2(MAX_SEG);
    localparam int CNT_W   = $clog2(MAX_SEG + 1);

    localparam logic [LEN_W-1:0] SPACE_RESET = LEN_W'(1024);

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_COMPACT = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic               used;
        logic [ID_BITS-1:0] owner;
        logic [LEN_W-1:0]   len;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
endpackage
`default_nettype wire

// ===== rtl/first_fit_space_allocator_top.sv =====
// Segment-table sequencer: first-fit insert, remove with merge, compaction.
// Each table entry scanned, compacted or shifted takes a read state and then
//   a second state that uses the registered read data, plus fixed steps.
// Throughput: one command at a time; the table RAM's read is registered.
//   Result held in an output register.
// Reset (synchronous, active low) and any config write pass through S_INIT,
//   which writes the initial free segment before the next command is taken.
`default_nettype none
module first_fit_space_allocator_top
    import ffsa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [1:0]       i_cmd,
    input  wire logic [15:0]      i_file_id,
    input  wire logic [LEN_W-1:0] i_size_kb,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic      [1:0]       o_status,
    output logic      [LEN_W-1:0] o_free_kb,
    output logic      [LEN_W-1:0] o_placed_at_kb,
    output logic                  o_space_full
);
    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_EX, S_NEXT_RD, S_NEXT_EX,
        S_MERGE_A, S_MERGE_B, S_MERGE_W, S_SHL_RD, S_SHL_WR,
        S_CMP_RD, S_CMP_EX, S_CMP_TAIL, S_CARVE_CHK, S_SHR_RD, S_SHR_WR,
        S_CARVE_A, S_CARVE_B, S_DONE
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [ID_BITS-1:0] r_id;
    logic [LEN_W-1:0]   r_size, r_acc, r_free, r_space, r_len, r_prev_len, r_nlen;
    logic [LEN_W-1:0]   r_placed;
    logic [CNT_W-1:0]   r_k, r_w, r_cnt, r_tgt;
    logic               r_exists, r_prev_free, r_nf, r_full;
    logic [1:0]         r_drop;
    t_status            r_status;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    t_entry             ram_wdata, rd;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               accept;
    logic [CNT_W:0]     k_plus_d, tgt_plus1;

    assign rd         = t_entry'(ram_rdata);
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign k_plus_d   = {1'b0, r_k} + (CNT_W+1)'(r_drop);
    assign tgt_plus1  = {1'b0, r_tgt} + (CNT_W+1)'(1);

    ffsa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEG)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ram_raddr = r_k[IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_k[IDX_W-1:0];
        ram_wdata = rd;
        unique case (r_state)
            S_SHL_RD: ram_raddr = k_plus_d[IDX_W-1:0];
            S_SHR_RD: ram_raddr = IDX_W'(r_k - CNT_W'(1));
            S_INIT: begin
                ram_we    = (r_space != '0);
                ram_waddr = '0;
                ram_wdata = '{used: 1'b0, owner: '0, len: r_space};
            end
            S_MERGE_W: begin
                ram_we    = (r_len != '0);
                ram_waddr = r_tgt[IDX_W-1:0];
                ram_wdata = '{used: 1'b0, owner: '0, len: r_len};
            end
            S_SHL_WR, S_SHR_WR: ram_we = 1'b1;
            S_CMP_EX: begin
                ram_we    = rd.used;
                ram_waddr = r_w[IDX_W-1:0];
            end
            S_CMP_TAIL: begin
                ram_we    = (r_free != '0) && (r_w < CNT_W'(MAX_SEG));
                ram_waddr = r_w[IDX_W-1:0];
                ram_wdata = '{used: 1'b0, owner: '0, len: r_free};
            end
            S_CARVE_CHK: begin
                ram_we    = r_exists && (r_len == r_size);
                ram_waddr = r_tgt[IDX_W-1:0];
                ram_wdata = '{used: 1'b1, owner: r_id, len: r_size};
            end
            S_CARVE_A: begin
                ram_we    = r_exists;
                ram_waddr = tgt_plus1[IDX_W-1:0];
                ram_wdata = '{used: 1'b0, owner: '0, len: r_len - r_size};
            end
            S_CARVE_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_tgt[IDX_W-1:0];
                ram_wdata = '{used: 1'b1, owner: r_id, len: r_size};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_space     <= SPACE_RESET;
            r_full      <= 1'b0;
            r_cnt       <= '0;
            r_free      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // a result loaded in S_DONE this cycle takes over the valid bit
            if (o_out_valid && !i_out_stall && (i_cfg_we || r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_space <= i_cfg_data;
                r_state <= S_INIT;
            end else begin
                unique case (r_state)
                    S_INIT: begin
                        r_cnt   <= (r_space != '0) ? CNT_W'(1) : '0;
                        r_free  <= r_space;
                        r_full  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (accept) begin
                            r_cmd       <= t_cmd'(i_cmd);
                            r_id        <= i_file_id[ID_BITS-1:0];
                            r_size      <= i_size_kb;
                            r_k         <= '0;
                            r_w         <= '0;
                            r_acc       <= '0;
                            r_prev_free <= 1'b0;
                            r_prev_len  <= '0;
                            r_placed    <= '0;
                            r_status    <= ST_OK;
                            if (r_full) begin
                                r_status <= ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                unique case (t_cmd'(i_cmd))
                                    CMD_INSERT: begin
                                        if (i_size_kb > r_free) begin
                                            r_full   <= 1'b1;
                                            r_status <= ST_FULL;
                                            r_state  <= S_DONE;
                                        end else begin
                                            r_state <= S_SCAN_RD;
                                        end
                                    end
                                    CMD_REMOVE:  r_state <= S_SCAN_RD;
                                    CMD_COMPACT: r_state <= S_CMP_RD;
                                    default:     r_state <= S_DONE;
                                endcase
                            end
                        end
                    end
                    S_SCAN_RD: begin
                        if (r_k == r_cnt) begin
                            if (r_cmd == CMD_INSERT) begin
                                r_k     <= '0;
                                r_acc   <= '0;
                                r_state <= S_CMP_RD;
                            end else begin
                                r_status <= ST_NOTFOUND;
                                r_state  <= S_DONE;
                            end
                        end else begin
                            r_state <= S_SCAN_EX;
                        end
                    end
                    S_SCAN_EX: begin
                        if (r_cmd == CMD_INSERT) begin
                            if (!rd.used && rd.len >= r_size) begin
                                r_tgt    <= r_k;
                                r_exists <= 1'b1;
                                r_len    <= rd.len;
                                r_placed <= r_acc;
                                r_state  <= S_CARVE_CHK;
                            end else begin
                                r_acc   <= r_acc + rd.len;
                                r_k     <= r_k + CNT_W'(1);
                                r_state <= S_SCAN_RD;
                            end
                        end else if (rd.used && rd.owner == r_id) begin
                            r_tgt <= r_k;
                            r_len <= rd.len;
                            r_nf  <= 1'b0;
                            r_k   <= r_k + CNT_W'(1);
                            // only look at the right neighbor when it exists
                            r_state <= ((r_k + CNT_W'(1)) < r_cnt) ? S_NEXT_RD : S_MERGE_A;
                        end else begin
                            r_prev_free <= !rd.used;
                            r_prev_len  <= rd.len;
                            r_k         <= r_k + CNT_W'(1);
                            r_state     <= S_SCAN_RD;
                        end
                    end
                    S_NEXT_RD: r_state <= S_NEXT_EX;
                    S_NEXT_EX: begin
                        r_nf    <= !rd.used;
                        r_nlen  <= rd.len;
                        r_state <= S_MERGE_A;
                    end
                    S_MERGE_A: begin
                        r_free  <= r_free + r_len;
                        r_len   <= r_len + (r_nf ? r_nlen : '0);
                        r_state <= S_MERGE_B;
                    end
                    S_MERGE_B: begin
                        r_len   <= r_len + (r_prev_free ? r_prev_len : '0);
                        r_tgt   <= r_prev_free ? r_tgt - CNT_W'(1) : r_tgt;
                        r_drop  <= {1'b0, r_nf} + {1'b0, r_prev_free};
                        r_state <= S_MERGE_W;
                    end
                    S_MERGE_W: begin
                        if (r_len != '0) begin
                            r_k     <= tgt_plus1[CNT_W-1:0];
                            r_state <= (r_drop != '0) ? S_SHL_RD : S_DONE;
                        end else begin
                            // zero-length freed segment with no neighbor: drop it
                            r_k     <= r_tgt;
                            r_drop  <= 2'd1;
                            r_state <= S_SHL_RD;
                        end
                    end
                    S_SHL_RD: begin
                        if (k_plus_d >= {1'b0, r_cnt}) begin
                            r_cnt   <= r_cnt - CNT_W'(r_drop);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SHL_WR;
                        end
                    end
                    S_SHL_WR: begin
                        r_k     <= r_k + CNT_W'(1);
                        r_state <= S_SHL_RD;
                    end
                    S_CMP_RD: r_state <= (r_k == r_cnt) ? S_CMP_TAIL : S_CMP_EX;
                    S_CMP_EX: begin
                        if (rd.used) begin
                            r_w   <= r_w + CNT_W'(1);
                            r_acc <= r_acc + rd.len;
                        end
                        r_k     <= r_k + CNT_W'(1);
                        r_state <= S_CMP_RD;
                    end
                    S_CMP_TAIL: begin
                        r_tgt    <= r_w;
                        r_placed <= (r_cmd == CMD_INSERT) ? r_acc : '0;
                        r_len    <= r_free;
                        if ((r_free != '0) && (r_w < CNT_W'(MAX_SEG))) begin
                            r_cnt    <= r_w + CNT_W'(1);
                            r_exists <= 1'b1;
                        end else begin
                            r_cnt    <= r_w;
                            r_exists <= 1'b0;
                        end
                        r_state <= (r_cmd == CMD_INSERT) ? S_CARVE_CHK : S_DONE;
                    end
                    S_CARVE_CHK: begin
                        if (r_exists && r_len == r_size) begin
                            r_free  <= r_free - r_size;
                            r_state <= S_DONE;
                        end else if (r_cnt >= CNT_W'(MAX_SEG)) begin
                            r_status <= ST_OVERFLOW;
                            r_placed <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_k     <= r_cnt;
                            r_state <= S_SHR_RD;
                        end
                    end
                    S_SHR_RD: begin
                        r_state <= ({1'b0, r_k} > tgt_plus1) ? S_SHR_WR : S_CARVE_A;
                    end
                    S_SHR_WR: begin
                        r_k     <= r_k - CNT_W'(1);
                        r_state <= S_SHR_RD;
                    end
                    S_CARVE_A: r_state <= S_CARVE_B;
                    S_CARVE_B: begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_free  <= r_free - r_size;
                        r_state <= S_DONE;
                    end
                    S_DONE: begin
                        if (!o_out_valid || !i_out_stall) begin
                            o_out_valid    <= 1'b1;
                            o_status       <= r_status;
                            o_free_kb      <= r_free;
                            o_placed_at_kb <= r_placed;
                            o_space_full   <= r_full;
                            r_state        <= S_IDLE;
                        end
                    end
                    default: r_state <= S_INIT;
                endcase
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SEG))
        else $error("segment count above table depth");

    // free total is loaded from a new space size in S_INIT, so that state is excluded
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> (r_free <= r_space))
        else $error("free total exceeds managed space");

    a_full_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_full && !i_cfg_we) |=> (r_state == S_DONE && r_status == ST_FULL))
        else $error("command not ignored while full");

    a_no_out_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && o_out_valid && i_out_stall && !i_cfg_we)
            |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");
endmodule
`default_nettype wire

// ===== rtl/ffsa_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== dv/tb_first_fit_space_allocator_top.sv =====
// Self-checking testbench for the first-fit space allocator: random and directed commands.
`timescale 1ns / 1ps
module tb_first_fit_space_allocator_top
    import ffsa_pkg::*;
;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        t_status          st;
        logic [LEN_W-1:0] free_kb;
        logic [LEN_W-1:0] placed;
        logic             full;
    } t_alloc_result;

    class alloc_scoreboard;
        logic [31:0]        seg_len[MAX_SEG];
        logic               seg_used[MAX_SEG];
        logic [ID_BITS-1:0] seg_owner[MAX_SEG];
        int                 seg_cnt;
        logic [31:0]        free_total;
        logic               full_flag;
        t_alloc_result      expected_q[$];
        int                 errors;

        function void set_space(logic [LEN_W-1:0] s);
            for (int k = 0; k < MAX_SEG; k++) begin
                seg_len[k] = '0;
                seg_used[k] = 1'b0;
                seg_owner[k] = '0;
            end
            seg_cnt = 0;
            if (s != '0) begin
                seg_len[0] = 32'(s);
                seg_cnt = 1;
            end
            free_total = 32'(s);
            full_flag = 1'b0;
        endfunction

        function void drop_seg(int i);
            if (i >= seg_cnt) return;
            for (int k = i; k + 1 < seg_cnt; k++) begin
                seg_len[k] = seg_len[k+1];
                seg_used[k] = seg_used[k+1];
                seg_owner[k] = seg_owner[k+1];
            end
            seg_cnt--;
        endfunction

        function void open_seg(int i);
            for (int k = seg_cnt; k > i; k--) begin
                seg_len[k] = seg_len[k-1];
                seg_used[k] = seg_used[k-1];
                seg_owner[k] = seg_owner[k-1];
            end
            seg_cnt++;
        endfunction

        function void gather_free();
            int w;
            w = 0;
            for (int r = 0; r < seg_cnt; r++) begin
                if (seg_used[r]) begin
                    seg_len[w] = seg_len[r];
                    seg_used[w] = 1'b1;
                    seg_owner[w] = seg_owner[r];
                    w++;
                end
            end
            seg_cnt = w;
            if (free_total != '0 && seg_cnt < MAX_SEG) begin
                seg_len[w] = free_total;
                seg_used[w] = 1'b0;
                seg_owner[w] = '0;
                seg_cnt++;
            end
        endfunction

        function t_status insert_file(logic [ID_BITS-1:0] id, logic [31:0] size,
                                      output logic [31:0] placed);
            int i;
            placed = '0;
            if (size > free_total) begin
                full_flag = 1'b1;
                return ST_FULL;
            end
            for (i = 0; i < seg_cnt; i++)
                if (!seg_used[i] && seg_len[i] >= size) break;
            if (i == seg_cnt) begin
                gather_free();
                i = seg_cnt;
                if (seg_cnt > 0 && !seg_used[seg_cnt-1]) i = seg_cnt - 1;
            end
            if (i < seg_cnt && seg_len[i] == size) begin
                seg_used[i] = 1'b1;
                seg_owner[i] = id;
            end else begin
                if (seg_cnt >= MAX_SEG) return ST_OVERFLOW;
                open_seg(i);
                seg_len[i] = size;
                seg_used[i] = 1'b1;
                seg_owner[i] = id;
                if (i + 1 < seg_cnt) seg_len[i+1] -= size;
            end
            free_total -= size;
            for (int k = 0; k < i && k < seg_cnt; k++) placed += seg_len[k];
            return ST_OK;
        endfunction

        function t_status remove_file(logic [ID_BITS-1:0] id);
            int i;
            for (i = 0; i < seg_cnt; i++)
                if (seg_used[i] && seg_owner[i] == id) break;
            if (i == seg_cnt) return ST_NOTFOUND;
            seg_used[i] = 1'b0;
            free_total += seg_len[i];
            if (i + 1 < seg_cnt && !seg_used[i+1]) begin
                seg_len[i] += seg_len[i+1];
                drop_seg(i + 1);
            end
            if (i > 0 && !seg_used[i-1]) begin
                seg_len[i-1] += seg_len[i];
                drop_seg(i);
                i--;
            end
            if (seg_len[i] == '0) drop_seg(i);
            return ST_OK;
        endfunction

        function void note_command(t_cmd cmd, logic [15:0] id, logic [LEN_W-1:0] size);
            t_alloc_result r;
            logic [31:0] placed;
            placed = '0;
            r.st = ST_OK;
            if (full_flag) r.st = ST_FULL;
            else if (cmd == CMD_INSERT)
                r.st = insert_file(id[ID_BITS-1:0], 32'(size), placed);
            else if (cmd == CMD_REMOVE) r.st = remove_file(id[ID_BITS-1:0]);
            else if (cmd == CMD_COMPACT) gather_free();
            r.free_kb = free_total[LEN_W-1:0];
            r.placed = placed[LEN_W-1:0];
            r.full = full_flag;
            expected_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("%0t: mismatch %s got %0d expected %0d", $time, what, got, want);
        endtask

        task check_result(logic [1:0] st, logic [LEN_W-1:0] free_kb,
                          logic [LEN_W-1:0] placed, logic full);
            t_alloc_result e;
            if (expected_q.size() == 0) begin
                report("unexpected result, status", 32'(st), '0);
                return;
            end
            e = expected_q.pop_front();
            if (st != e.st) report("status", 32'(st), 32'(e.st));
            if (free_kb != e.free_kb) report("free_kb", 32'(free_kb), 32'(e.free_kb));
            if (placed != e.placed) report("placed_at_kb", 32'(placed), 32'(e.placed));
            if (full != e.full) report("space_full", 32'(full), 32'(e.full));
        endtask
    endclass

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_cfg_we = 0;
    logic [LEN_W-1:0] i_cfg_data = 0;
    logic             i_in_valid = 0;
    logic             o_in_stall;
    logic [1:0]       i_cmd = 0;
    logic [15:0]      i_file_id = 0;
    logic [LEN_W-1:0] i_size_kb = 0;
    logic             o_out_valid;
    logic             i_out_stall = 0;
    logic [1:0]       o_status;
    logic [LEN_W-1:0] o_free_kb;
    logic [LEN_W-1:0] o_placed_at_kb;
    logic             o_space_full;

    alloc_scoreboard sb = new();
    bit              quiet = 0;
    bit              hold_req = 0;
    int              cycles = 0;
    logic [LEN_W-1:0] space_now;

    first_fit_space_allocator_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_cmd(i_cmd),
        .i_file_id(i_file_id), .i_size_kb(i_size_kb), .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall), .o_status(o_status), .o_free_kb(o_free_kb),
        .o_placed_at_kb(o_placed_at_kb), .o_space_full(o_space_full)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_command(t_cmd'(i_cmd), i_file_id, i_size_kb);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_free_kb, o_placed_at_kb, o_space_full);
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stalls: random bursts, plus one long hold on request
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_cmd(t_cmd cmd, logic [15:0] id, logic [LEN_W-1:0] size);
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_file_id <= id;
        i_size_kb <= size;
        do @(posedge i_clk); while (o_in_stall);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_space(logic [LEN_W-1:0] s);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_space(s);
        space_now = s;
    endtask

    task automatic random_phase(int n_items, int max_size);
        t_cmd        cmd;
        logic [15:0] id;
        logic [31:0] size;
        int          pick;
        for (int n = 0; n < n_items; n++) begin
            if (sb.full_flag) begin
                // one ignored command while full, then start the space over
                send_cmd(t_cmd'($urandom_range(0, 3)), 16'($urandom), LEN_W'($urandom));
                write_space(space_now);
                continue;
            end
            pick = $urandom_range(0, 99);
            cmd = pick < 50 ? CMD_INSERT : pick < 85 ? CMD_REMOVE :
                  pick < 95 ? CMD_COMPACT : CMD_NOP;
            id = $urandom_range(0, 9) < 8 ? 16'($urandom_range(0, 15)) : 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 85) size = $urandom_range(1, max_size);
            else if (pick < 90) size = '0;
            else if (pick < 96) size = sb.free_total;
            else size = $urandom & 32'h7FFF_FFFF;
            send_cmd(cmd, id, size[LEN_W-1:0]);
        end
    endtask

    initial begin
        space_now = SPACE_RESET;
        sb.set_space(SPACE_RESET);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: holes, zero size, exact fit, unknown id, nop, full
        send_cmd(CMD_INSERT, 16'd1, LEN_W'(100));
        send_cmd(CMD_INSERT, 16'd2, LEN_W'(0));
        send_cmd(CMD_INSERT, 16'hFFFF, LEN_W'(200));
        send_cmd(CMD_INSERT, 16'd3, LEN_W'(300));
        send_cmd(CMD_REMOVE, 16'h1234, LEN_W'(0));
        send_cmd(CMD_REMOVE, 16'd1, LEN_W'(0));
        send_cmd(CMD_INSERT, 16'd4, LEN_W'(150));
        send_cmd(CMD_REMOVE, 16'hFFFF, LEN_W'(0));
        send_cmd(CMD_COMPACT, 16'd0, LEN_W'(0));
        send_cmd(CMD_NOP, 16'hAAAA, 31'h5555_5555);
        send_cmd(CMD_INSERT, 16'd5, LEN_W'(424));
        send_cmd(CMD_INSERT, 16'd6, LEN_W'(0));
        send_cmd(CMD_REMOVE, 16'd3, LEN_W'(0));
        send_cmd(CMD_INSERT, 16'd7, 31'h7FFF_FFFF);
        send_cmd(CMD_REMOVE, 16'd5, LEN_W'(0));
        write_space(LEN_W'(1));
        send_cmd(CMD_INSERT, 16'h5555, LEN_W'(1));
        send_cmd(CMD_REMOVE, 16'h5555, LEN_W'(0));
        write_space(31'h7FFF_FFFF);
        send_cmd(CMD_INSERT, 16'hFFFF, 31'h7FFF_FFFF);
        send_cmd(CMD_REMOVE, 16'hFFFF, LEN_W'(0));
        send_cmd(CMD_INSERT, 16'h8000, 31'h4000_0000);

        // tiny files to run the segment table into overflow
        write_space(LEN_W'(1000));
        random_phase(90, 3);
        // sender keeps offering while the receiver holds off
        hold_req = 1;
        random_phase(20, 40);
        write_space(LEN_W'(5000));
        random_phase(50, 200);
        drain();
        write_space(31'h7FFF_FFFF);
        random_phase(50, 32'h0100_0000);
        write_space(LEN_W'(300));
        random_phase(50, 20);
        write_space(LEN_W'($urandom_range(64, 1 << 20)));
        random_phase(50, 32'(space_now) / 16 + 1);
        write_space(LEN_W'(1024));
        quiet = 1;
        random_phase(60, 40);

        drain();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
